// ===== hw/rtl/mdn_pkg.sv =====
`default_nettype none

package mdn_pkg;

    localparam int CODE_W     = 64;
    localparam int NUM_COORDS = 8;
    localparam int DIMS_W     = 4;
    localparam int RATIO_W    = 4;
    localparam int RATIOS_W   = NUM_COORDS * RATIO_W;
    localparam int CFG_W      = 32;

    localparam int COORD_0_W = 64;
    localparam int COORD_1_W = 32;
    localparam int COORD_2_W = 21;
    localparam int COORD_3_W = 16;
    localparam int COORD_4_W = 12;
    localparam int COORD_5_W = 10;
    localparam int COORD_6_W = 9;
    localparam int COORD_7_W = 8;

    // coordinate width for an n-dimensional code, index 0 unused
    localparam int COORD_W [9] = '{0, 64, 32, 21, 16, 12, 10, 9, 8};

    localparam logic [DIMS_W-1:0]   DIMS_RESET   = 4'd2;
    localparam logic [DIMS_W-1:0]   DIMS_MAX     = 4'd8;
    localparam logic [RATIOS_W-1:0] RATIOS_RESET = 32'h1111_1111;

    typedef enum logic [0:0] {
        REG_DIMENSIONS    = 1'b0,
        REG_SHRINK_RATIOS = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [DIMS_W-1:0]   dims;
        logic [RATIOS_W-1:0] ratios;
    } t_ctl;

    typedef logic [NUM_COORDS-1:0][CODE_W-1:0] t_coords;

    // component d of v taken as an n-dimensional interleaved code
    function automatic logic [CODE_W-1:0] deinterleave(
        input logic [CODE_W-1:0] v,
        input logic [DIMS_W-1:0] n,
        input int                d
    );
        logic [CODE_W-1:0] r;
        r = '0;
        for (int nn = 1; nn <= NUM_COORDS; nn++) begin
            if (n == DIMS_W'(nn)) begin
                for (int i = 0; i < CODE_W; i++) begin
                    if (i < COORD_W[nn] && i * nn + d < CODE_W) begin
                        r[i] = v[i * nn + d];
                    end
                end
            end
        end
        return r;
    endfunction

    // keep the last component of a k-dimensional split, pass through otherwise
    function automatic logic [CODE_W-1:0] shrink(
        input logic [CODE_W-1:0]  v,
        input logic [RATIO_W-1:0] k
    );
        logic [CODE_W-1:0] r;
        r = v;
        for (int nn = 2; nn <= NUM_COORDS; nn++) begin
            if (k == RATIO_W'(nn)) begin
                r = deinterleave(v, DIMS_W'(nn), nn - 1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/morton_decode_nd_shrink_unit.sv =====
`default_nettype none

// Morton (Z-order) decoder: each 64-bit code item is split into up to eight
// coordinates (dimensions register, values 0 and above 8 saturate to 1 and 8),
// then each coordinate is optionally shrunk by its own ratio nibble.
// Throughput is one item per cycle while the output is not stalled. The
// pipeline has three register stages: the input register, the de-interleave
// stage and the shrink stage. Each stage holds its item under backpressure.
// o_coord_valid rises once the item has passed from the input register
// through the de-interleave and shrink stages.
// Register writes apply to items accepted after the write; unused coordinates
// read as zero.
module morton_decode_nd_shrink_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_index,
    input  wire logic [mdn_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  wire logic                             i_code_valid,
    output logic                                  o_code_ready,
    input  wire logic [mdn_pkg::CODE_W-1:0]       i_code,
    output logic                                  o_coord_valid,
    input  wire logic                             i_coord_ready,
    output logic [mdn_pkg::COORD_0_W-1:0]         o_coord_0,
    output logic [mdn_pkg::COORD_1_W-1:0]         o_coord_1,
    output logic [mdn_pkg::COORD_2_W-1:0]         o_coord_2,
    output logic [mdn_pkg::COORD_3_W-1:0]         o_coord_3,
    output logic [mdn_pkg::COORD_4_W-1:0]         o_coord_4,
    output logic [mdn_pkg::COORD_5_W-1:0]         o_coord_5,
    output logic [mdn_pkg::COORD_6_W-1:0]         o_coord_6,
    output logic [mdn_pkg::COORD_7_W-1:0]         o_coord_7
);

    logic [mdn_pkg::DIMS_W-1:0]   r_dims;
    logic [mdn_pkg::RATIOS_W-1:0] r_ratios;
    logic [mdn_pkg::DIMS_W-1:0]   n_dims;

    logic                         r_s1_valid;
    logic [mdn_pkg::CODE_W-1:0]   r_s1_code;
    mdn_pkg::t_ctl                r_s1_ctl;
    logic                         split_ready;

    logic                         split_valid;
    logic                         shrink_ready;
    mdn_pkg::t_coords             split_coords;
    mdn_pkg::t_ctl                split_ctl;
    mdn_pkg::t_coords             out_coords;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims   <= mdn_pkg::DIMS_RESET;
            r_ratios <= mdn_pkg::RATIOS_RESET;
        end else if (i_cfg_we) begin
            unique case (mdn_pkg::t_reg_index'(i_cfg_index))
                mdn_pkg::REG_DIMENSIONS: begin
                    r_dims <= i_cfg_wdata[mdn_pkg::DIMS_W-1:0];
                end
                mdn_pkg::REG_SHRINK_RATIOS: begin
                    r_ratios <= i_cfg_wdata[mdn_pkg::RATIOS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // saturate dimension count to 1..8
    always_comb begin
        if (r_dims == '0) begin
            n_dims = mdn_pkg::DIMS_W'(1);
        end else if (r_dims > mdn_pkg::DIMS_MAX) begin
            n_dims = mdn_pkg::DIMS_MAX;
        end else begin
            n_dims = r_dims;
        end
    end

    assign o_code_ready = !r_s1_valid || split_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_code_ready) begin
            r_s1_valid <= i_code_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_code_ready && i_code_valid) begin
            r_s1_code       <= i_code;
            r_s1_ctl.dims   <= n_dims;
            r_s1_ctl.ratios <= r_ratios;
        end
    end

    mdn_split u_split (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .o_ready  (split_ready),
        .i_code   (r_s1_code),
        .i_ctl    (r_s1_ctl),
        .o_valid  (split_valid),
        .i_ready  (shrink_ready),
        .o_coords (split_coords),
        .o_ctl    (split_ctl)
    );

    mdn_shrink u_shrink (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (split_valid),
        .o_ready  (shrink_ready),
        .i_coords (split_coords),
        .i_ratios (split_ctl.ratios),
        .o_valid  (o_coord_valid),
        .i_ready  (i_coord_ready),
        .o_coords (out_coords)
    );

    assign o_coord_0 = out_coords[0][mdn_pkg::COORD_0_W-1:0];
    assign o_coord_1 = out_coords[1][mdn_pkg::COORD_1_W-1:0];
    assign o_coord_2 = out_coords[2][mdn_pkg::COORD_2_W-1:0];
    assign o_coord_3 = out_coords[3][mdn_pkg::COORD_3_W-1:0];
    assign o_coord_4 = out_coords[4][mdn_pkg::COORD_4_W-1:0];
    assign o_coord_5 = out_coords[5][mdn_pkg::COORD_5_W-1:0];
    assign o_coord_6 = out_coords[6][mdn_pkg::COORD_6_W-1:0];
    assign o_coord_7 = out_coords[7][mdn_pkg::COORD_7_W-1:0];

    // dimension count in flight is always saturated
    a_dims_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_ctl.dims != '0) && (r_s1_ctl.dims <= mdn_pkg::DIMS_MAX))
        else $error("dimension count out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/mdn_split.sv =====
`default_nettype none

module mdn_split (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [mdn_pkg::CODE_W-1:0]     i_code,
    input  wire mdn_pkg::t_ctl                  i_ctl,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output mdn_pkg::t_coords                    o_coords,
    output mdn_pkg::t_ctl                       o_ctl
);

    logic             r_valid;
    mdn_pkg::t_coords r_coords;
    mdn_pkg::t_coords n_coords;
    mdn_pkg::t_ctl    r_ctl;

    assign o_ready = !r_valid || i_ready;

    for (genvar d = 0; d < mdn_pkg::NUM_COORDS; d++) begin : g_coord
        always_comb begin
            if (i_ctl.dims > mdn_pkg::DIMS_W'(d)) begin
                n_coords[d] = mdn_pkg::deinterleave(i_code, i_ctl.dims, d);
            end else begin
                n_coords[d] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_coords <= n_coords;
            r_ctl    <= i_ctl;
        end
    end

    assign o_valid  = r_valid;
    assign o_coords = r_coords;
    assign o_ctl    = r_ctl;

    // the last coordinate is only populated at full dimension count
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_ctl.dims == mdn_pkg::DIMS_MAX)
                    || (r_coords[mdn_pkg::NUM_COORDS-1] == '0))
        else $error("unused coordinate not zero");

endmodule

`default_nettype wire

// ===== hw/rtl/mdn_shrink.sv =====
`default_nettype none

module mdn_shrink (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire mdn_pkg::t_coords               i_coords,
    input  wire logic [mdn_pkg::RATIOS_W-1:0]   i_ratios,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output mdn_pkg::t_coords                    o_coords
);

    logic             r_valid;
    mdn_pkg::t_coords r_coords;
    mdn_pkg::t_coords n_coords;

    assign o_ready = !r_valid || i_ready;

    for (genvar d = 0; d < mdn_pkg::NUM_COORDS; d++) begin : g_coord
        assign n_coords[d] = mdn_pkg::shrink(
            i_coords[d], i_ratios[d*mdn_pkg::RATIO_W +: mdn_pkg::RATIO_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_coords <= n_coords;
        end
    end

    assign o_valid  = r_valid;
    assign o_coords = r_coords;

    // a ratio of one leaves the coordinate untouched
    a_ratio_one_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_ratios[mdn_pkg::RATIO_W-1:0] == mdn_pkg::RATIO_W'(1))
        |=> r_coords[0] == $past(i_coords[0]))
        else $error("coordinate changed at ratio one");

endmodule

`default_nettype wire
